// ----- sv/rap_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, codes and helpers of the register access packet engine.
// ----------------------------------------------------------------------------
package rap_pkg;

  localparam logic [7:0] SET_BASE = 8'd200;
  localparam logic [7:0] GET_BASE = 8'd100;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic [2:0] REG_SYNC       = 3'd0;
  localparam logic [2:0] REG_REPLY_SYNC = 3'd1;
  localparam logic [2:0] REG_CODE_SET   = 3'd2;
  localparam logic [2:0] REG_CODE_PUT   = 3'd3;
  localparam logic [2:0] REG_CODE_GET   = 3'd4;
  localparam logic [2:0] REG_CODE_FPT   = 3'd5;
  localparam logic [2:0] REG_CODE_FGT   = 3'd6;

  // field put executes exactly like set and shares its kind
  typedef enum logic [2:0] {
    K_NONE,
    K_SET,
    K_PUT,
    K_GET,
    K_FGT
  } kind_t;

  typedef struct packed {
    logic [7:0] sync;
    logic [7:0] reply_sync;
    logic [7:0] code_set;
    logic [7:0] code_put;
    logic [7:0] code_get;
    logic [7:0] code_fpt;
    logic [7:0] code_fgt;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] status;
    logic [7:0] addr;
    logic [7:0] length;
    logic [7:0] mask;
    logic [7:0] shift;
  } cmd_t;

  function automatic logic [7:0] shl8(input logic [7:0] v, input logic [7:0] s);
    return (s >= 8'd8) ? 8'd0 : 8'(v << s[2:0]);
  endfunction

  function automatic logic [7:0] shr8(input logic [7:0] v, input logic [7:0] s);
    return (s >= 8'd8) ? 8'd0 : 8'(v >> s[2:0]);
  endfunction

endpackage
`default_nettype wire

// ----- sv/register_access_packet_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// register_access_packet_engine
// Parses register access request packets and produces reply bursts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/rx_byte): one received byte per beat. The
// parser takes a beat every cycle; only the checksum beat can stall, when
// both command queue entries are occupied.
// Output channel (out_valid/out_ready/tx_byte/reply_end): reply bytes, one
// per beat; reply_end marks the reply checksum.
// The checksum beat pushes the command into the queue; the executor pops it,
// writes one store entry per cycle (one for a single write, length for a
// block write) and loads reply bytes into the output register. Reply bytes
// follow one per cycle while out_ready is high; a reply is 3 to
// STORE_BYTES + 3 beats. A stalled receiver holds the output register; the
// executor waits and the parser keeps taking bytes until the queue fills.
// Reset clears the parser to sync hunting, empties the queue, zeroes the
// register store and loads the configuration defaults.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// ----------------------------------------------------------------------------
module register_access_packet_engine #(
  parameter int STORE_BYTES = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       reply_end,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rap_pkg::*;

  localparam int PW = STORE_BYTES * 8;
  localparam int QW = $bits(cmd_t) + PW;

  cfg_t          cfg;
  logic          push;
  cmd_t          f_cmd;
  logic [PW-1:0] f_pay;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_rdata;
  cmd_t          q_cmd;
  logic [PW-1:0] q_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync       <= 8'd170;
      cfg.reply_sync <= 8'd85;
      cfg.code_set   <= 8'd1;
      cfg.code_put   <= 8'd2;
      cfg.code_get   <= 8'd3;
      cfg.code_fpt   <= 8'd4;
      cfg.code_fgt   <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC:       cfg.sync       <= cfg_data;
        REG_REPLY_SYNC: cfg.reply_sync <= cfg_data;
        REG_CODE_SET:   cfg.code_set   <= cfg_data;
        REG_CODE_PUT:   cfg.code_put   <= cfg_data;
        REG_CODE_GET:   cfg.code_get   <= cfg_data;
        REG_CODE_FPT:   cfg.code_fpt   <= cfg_data;
        REG_CODE_FGT:   cfg.code_fgt   <= cfg_data;
        default:        cfg            <= cfg;
      endcase
    end
  end

  rap_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .cmd      (f_cmd),
    .pay      (f_pay)
  );

  rap_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  ({f_cmd, f_pay}),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  assign q_cmd = q_rdata[QW-1:PW];
  assign q_pay = q_rdata[PW-1:0];

  rap_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .q_pay      (q_pay),
    .reply_sync (cfg.reply_sync),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .reply_end  (reply_end)
  );

endmodule
`default_nettype wire

// ----- sv/rap_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rap_front
// Request parser: hunts for sync, collects header, data and checksum, and
// hands one classified command per packet to the command queue.
// ----------------------------------------------------------------------------
module rap_front #(
  parameter int STORE_BYTES = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  input  rap_pkg::cfg_t              cfg,
  input  logic                       q_full,
  output logic                       push,
  output rap_pkg::cmd_t              cmd,
  output logic [STORE_BYTES*8-1:0]   pay
);
  import rap_pkg::*;

  localparam int IW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [7:0] SB8 = 8'(STORE_BYTES);

  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_OPCODE = 8'b0000_0010,
    PH_ADDR   = 8'b0000_0100,
    PH_LENGTH = 8'b0000_1000,
    PH_MASK   = 8'b0001_0000,
    PH_SHIFT  = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_CHECK  = 8'b1000_0000
  } phase_t;

  phase_t     phase;
  logic [7:0] opcode;
  logic [7:0] addr;
  logic [7:0] length;
  logic [7:0] mask;
  logic [7:0] shift;
  logic [7:0] byte_index;
  logic [7:0] running_sum;
  logic [7:0] payload [STORE_BYTES];

  kind_t      kind;
  logic [1:0] status;
  logic       accept;
  logic [7:0] sum_next;
  logic [7:0] index_next;
  logic [7:0] set_off;
  logic [7:0] get_off;
  logic       set_bad;
  logic       get_bad;
  logic       len_bad;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (phase != PH_CHECK) || !q_full;
  assign sum_next   = running_sum + rx_byte;
  assign index_next = byte_index + 8'd1;

  always_comb begin
    if (opcode == cfg.code_set) begin
      kind = K_SET;
    end else if (opcode == cfg.code_put) begin
      kind = K_PUT;
    end else if (opcode == cfg.code_get) begin
      kind = K_GET;
    end else if (opcode == cfg.code_fpt) begin
      kind = K_SET;
    end else if (opcode == cfg.code_fgt) begin
      kind = K_FGT;
    end else begin
      kind = K_NONE;
    end
  end

  assign set_off = addr - SET_BASE;
  assign get_off = addr - GET_BASE;
  assign set_bad = (addr < SET_BASE) || (set_off >= SB8);
  assign get_bad = (addr < GET_BASE) || (get_off >= SB8);
  assign len_bad = (length == 8'd0) || (length > SB8);

  always_comb begin
    status = ST_OK;
    if (rx_byte != running_sum) begin
      status = ST_BAD_ADDR;
    end else begin
      case (kind)
        K_SET: status = set_bad ? ST_BAD_ADDR : ST_OK;
        K_PUT: status = (addr >= SB8) ? ST_BAD_ADDR : (len_bad ? ST_BAD_LEN : ST_OK);
        K_GET: status = get_bad ? ST_BAD_ADDR : (len_bad ? ST_BAD_LEN : ST_OK);
        K_FGT: status = get_bad ? ST_BAD_ADDR : ST_OK;
        default: status = ST_OK;
      endcase
    end
  end

  assign push = accept && (phase == PH_CHECK) && (kind != K_NONE);

  always_comb begin
    cmd.kind   = kind;
    cmd.status = status;
    cmd.addr   = addr;
    cmd.length = length;
    cmd.mask   = mask;
    cmd.shift  = shift;
    for (int j = 0; j < STORE_BYTES; j++) begin
      pay[j*8 +: 8] = payload[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      opcode      <= 8'd0;
      addr        <= 8'd0;
      length      <= 8'd0;
      mask        <= 8'd0;
      shift       <= 8'd0;
      byte_index  <= 8'd0;
      running_sum <= 8'd0;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          byte_index  <= 8'd0;
          running_sum <= 8'd0;
          if (rx_byte == cfg.sync) begin
            phase <= PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          opcode      <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_ADDR;
        end
        PH_ADDR: begin
          addr        <= rx_byte;
          running_sum <= sum_next;
          case (kind)
            K_SET, K_FGT: phase <= PH_MASK;
            K_PUT, K_GET: phase <= PH_LENGTH;
            default:      phase <= PH_HUNT;
          endcase
        end
        PH_LENGTH: begin
          length      <= rx_byte;
          running_sum <= sum_next;
          phase       <= (kind == K_PUT && rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
        end
        PH_MASK: begin
          mask        <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_SHIFT;
        end
        PH_SHIFT: begin
          shift       <= rx_byte;
          running_sum <= sum_next;
          phase       <= (kind == K_SET) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          running_sum <= sum_next;
          if (kind == K_PUT) begin
            byte_index <= index_next;
            if (index_next >= length) begin
              phase <= PH_CHECK;
            end
          end else begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

  // block write data is kept minus its index
  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && byte_index < SB8) begin
      payload[byte_index[IW-1:0]] <= rx_byte - byte_index;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rap_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rap_queue
// Two-entry command queue between parser and executor.
// ----------------------------------------------------------------------------
module rap_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full   = (count == 2'd2);
  assign rvalid = (count != 2'd0);
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/rap_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rap_back
// Command executor: owns the register store, performs writes one byte per
// cycle, and streams the reply through a one-beat output register.
// ----------------------------------------------------------------------------
module rap_back #(
  parameter int STORE_BYTES = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  rap_pkg::cmd_t             q_cmd,
  input  logic [STORE_BYTES*8-1:0]  q_pay,
  input  logic [7:0]                reply_sync,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                tx_byte,
  output logic                      reply_end
);
  import rap_pkg::*;

  localparam int IW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int AW = IW + 1;
  localparam logic [AW-1:0] SB_A = AW'(STORE_BYTES);

  typedef enum logic [5:0] {
    BK_IDLE  = 6'b00_0001,
    BK_WRITE = 6'b00_0010,
    BK_HDR   = 6'b00_0100,
    BK_STAT  = 6'b00_1000,
    BK_DATA  = 6'b01_0000,
    BK_SUM   = 6'b10_0000
  } bstate_t;

  bstate_t    state;
  cmd_t       cmd;
  logic [7:0] pay [STORE_BYTES];
  logic [7:0] store [STORE_BYTES];
  logic [AW-1:0] idx;
  logic [7:0] rsum;

  logic          ok;
  logic [7:0]    set_off;
  logic [7:0]    get_off;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_raw;
  logic [7:0]    data_byte;
  logic          idx_last;
  logic          emit;
  logic          out_load;
  logic          advance;
  logic [7:0]    out_byte;

  assign ok      = (cmd.status == ST_OK);
  assign set_off = cmd.addr - SET_BASE;
  assign get_off = cmd.addr - GET_BASE;
  assign q_pop   = (state == BK_IDLE) && q_valid;

  assign wr_addr = (cmd.kind == K_SET) ? {1'b0, set_off[IW-1:0]}
                                       : {1'b0, cmd.addr[IW-1:0]} + idx;
  assign wr_data = (cmd.kind == K_SET) ? (shl8(pay[0], cmd.shift) & cmd.mask)
                                       : pay[idx[IW-1:0]];
  assign wr_en   = (state == BK_WRITE) && (wr_addr < SB_A);

  // entries past the end of the store read as zero
  assign rd_addr   = {1'b0, get_off[IW-1:0]} + idx;
  assign rd_raw    = (rd_addr < SB_A) ? store[rd_addr[IW-1:0]] : 8'd0;
  assign data_byte = (cmd.kind == K_FGT) ? shr8(rd_raw & cmd.mask, cmd.shift)
                                         : rd_raw + 8'(idx);
  assign idx_last  = ((8'(idx) + 8'd1) == cmd.length);

  assign emit     = (state == BK_HDR) || (state == BK_STAT) ||
                    (state == BK_DATA) || (state == BK_SUM);
  assign out_load = !out_valid || out_ready;
  assign advance  = emit && out_load;

  always_comb begin
    case (state)
      BK_HDR:  out_byte = reply_sync;
      BK_STAT: out_byte = {6'd0, cmd.status};
      BK_DATA: out_byte = data_byte;
      BK_SUM:  out_byte = rsum;
      default: out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
      for (int j = 0; j < STORE_BYTES; j++) begin
        pay[j] <= q_pay[j*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
      rsum  <= 8'd0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (q_valid) begin
            idx <= '0;
            if (q_cmd.status == ST_OK && (q_cmd.kind == K_SET || q_cmd.kind == K_PUT)) begin
              state <= BK_WRITE;
            end else begin
              state <= BK_HDR;
            end
          end
        end
        BK_WRITE: begin
          if (cmd.kind == K_PUT && !idx_last) begin
            idx <= idx + AW'(1);
          end else begin
            state <= BK_HDR;
          end
        end
        BK_HDR: begin
          if (out_load) begin
            state <= BK_STAT;
          end
        end
        BK_STAT: begin
          if (out_load) begin
            rsum <= {6'd0, cmd.status};
            idx  <= '0;
            if (ok && (cmd.kind == K_GET || cmd.kind == K_FGT)) begin
              state <= BK_DATA;
            end else begin
              state <= BK_SUM;
            end
          end
        end
        BK_DATA: begin
          if (out_load) begin
            rsum <= rsum + data_byte;
            idx  <= idx + AW'(1);
            if (cmd.kind == K_FGT || idx_last) begin
              state <= BK_SUM;
            end
          end
        end
        BK_SUM: begin
          if (out_load) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < STORE_BYTES; j++) begin
        store[j] <= 8'd0;
      end
    end else if (wr_en) begin
      store[wr_addr[IW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_byte   <= out_byte;
      reply_end <= (state == BK_SUM);
    end
  end

endmodule
`default_nettype wire

// ----- sv/rap_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rap_checker
// Port-level checks of the packet engine, bound to the top level.
// ----------------------------------------------------------------------------
module rap_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] tx_byte,
  input wire logic       reply_end
);

  // stalled reply beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(reply_end))
    else $error("reply beat changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("reply beat valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("parser not ready after reset");

  // a reply never ends right after another reply ended
  a_end_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && reply_end |=> !(out_valid && reply_end))
    else $error("reply end beat without reply header");

endmodule

bind register_access_packet_engine rap_checker u_rap_checker (.*);
`default_nettype wire

// ----- dv/register_access_packet_engine_test.sv -----
// ----------------------------------------------------------------------------
// register_access_packet_engine_test
// Drives request packets into the packet engine one received byte per beat,
// predicts every reply byte from a behavioral copy of the parser, executor
// and register store, and checks each reply beat in order. Directed packets
// cover every opcode, bad address, bad length, bad checksum, unknown opcode,
// extreme and colliding opcode settings and opcodes renamed mid-packet;
// random packets follow under random configurations and random stalls.
// ----------------------------------------------------------------------------
module register_access_packet_engine_test;
  import rap_pkg::*;

  localparam int STORE_BYTES   = 2;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BYTES  = 100;

  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  typedef enum logic [2:0] {
    PH_HUNT, PH_OPCODE, PH_ADDR, PH_LENGTH, PH_MASK, PH_SHIFT, PH_DATA, PH_CHECK
  } phase_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] tx_byte;
  logic       reply_end;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = REG_SYNC;
  logic [7:0] cfg_data  = 8'd0;

  register_access_packet_engine #(.STORE_BYTES(STORE_BYTES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .reply_end (reply_end),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // engine shadow
  cfg_t       shadow_cfg;
  phase_t     eng_phase;
  logic [7:0] eng_opcode, eng_addr, eng_len, eng_mask, eng_shift, eng_index, eng_sum;
  logic [7:0] eng_payload[STORE_BYTES];
  logic [7:0] eng_store[STORE_BYTES];

  reply_beat_t pending_reply_bytes[$];

  bit burst_mode = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int replies_seen = 0;
  int reply_beats_seen = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  function automatic kind_t classify(input logic [7:0] op);
    if (op == shadow_cfg.code_set) return K_SET;
    if (op == shadow_cfg.code_put) return K_PUT;
    if (op == shadow_cfg.code_get) return K_GET;
    if (op == shadow_cfg.code_fpt) return K_SET;
    if (op == shadow_cfg.code_fgt) return K_FGT;
    return K_NONE;
  endfunction

  function automatic void predict_reply(input logic [7:0] b);
    kind_t      kind;
    logic [7:0] status, rsum, v, slot;
    kind   = classify(eng_opcode);
    status = 8'(ST_OK);
    rsum   = 8'd0;
    case (eng_phase)
      PH_HUNT: begin
        eng_index = 8'd0;
        eng_sum   = 8'd0;
        if (b == shadow_cfg.sync) eng_phase = PH_OPCODE;
      end
      PH_OPCODE: begin
        eng_opcode = b;
        eng_sum    = eng_sum + b;
        eng_phase  = PH_ADDR;
      end
      PH_ADDR: begin
        eng_addr = b;
        eng_sum  = eng_sum + b;
        if (kind == K_SET || kind == K_FGT) eng_phase = PH_MASK;
        else if (kind == K_PUT || kind == K_GET) eng_phase = PH_LENGTH;
        else eng_phase = PH_HUNT;
      end
      PH_LENGTH: begin
        eng_len   = b;
        eng_sum   = eng_sum + b;
        eng_phase = (kind == K_PUT && b != 8'd0) ? PH_DATA : PH_CHECK;
      end
      PH_MASK: begin
        eng_mask  = b;
        eng_sum   = eng_sum + b;
        eng_phase = PH_SHIFT;
      end
      PH_SHIFT: begin
        eng_shift = b;
        eng_sum   = eng_sum + b;
        eng_phase = (kind == K_SET) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        if (eng_index < STORE_BYTES) eng_payload[eng_index] = b - eng_index;
        eng_sum = eng_sum + b;
        if (kind == K_PUT) begin
          eng_index = eng_index + 8'd1;
          if (eng_index >= eng_len) eng_phase = PH_CHECK;
        end else begin
          eng_phase = PH_CHECK;
        end
      end
      default: begin
        eng_phase = PH_HUNT;
        if (kind != K_NONE) begin
          if (b != eng_sum) begin
            status = 8'(ST_BAD_ADDR);
          end else if (kind == K_SET) begin
            slot = eng_addr - SET_BASE;
            if (eng_addr < SET_BASE || slot >= STORE_BYTES) status = 8'(ST_BAD_ADDR);
            else eng_store[slot] = ((eng_shift >= 8'd8) ? 8'd0 :
                                    8'(eng_payload[0] << eng_shift)) & eng_mask;
          end else if (kind == K_PUT) begin
            if (eng_addr >= STORE_BYTES) status = 8'(ST_BAD_ADDR);
            else if (eng_len < 8'd1 || eng_len > STORE_BYTES) status = 8'(ST_BAD_LEN);
            else
              for (int i = 0; i < eng_len; i++)
                if (int'(eng_addr) + i < STORE_BYTES) eng_store[eng_addr + i] = eng_payload[i];
          end else begin
            slot = eng_addr - GET_BASE;
            if (eng_addr < GET_BASE || slot >= STORE_BYTES) status = 8'(ST_BAD_ADDR);
            else if (kind == K_GET && (eng_len < 8'd1 || eng_len > STORE_BYTES))
              status = 8'(ST_BAD_LEN);
          end
          pending_reply_bytes.push_back('{shadow_cfg.reply_sync, 1'b0});
          pending_reply_bytes.push_back('{status, 1'b0});
          rsum = status;
          if (status == 8'(ST_OK) && kind == K_GET) begin
            slot = eng_addr - GET_BASE;
            for (int i = 0; i < eng_len && i < STORE_BYTES; i++) begin
              v = (int'(slot) + i < STORE_BYTES) ? eng_store[slot + i] : 8'd0;
              v = v + 8'(i);
              pending_reply_bytes.push_back('{v, 1'b0});
              rsum = rsum + v;
            end
          end else if (status == 8'(ST_OK) && kind == K_FGT) begin
            slot = eng_addr - GET_BASE;
            v = eng_store[slot] & eng_mask;
            v = (eng_shift >= 8'd8) ? 8'd0 : (v >> eng_shift);
            pending_reply_bytes.push_back('{v, 1'b0});
            rsum = rsum + v;
          end
          pending_reply_bytes.push_back('{rsum, 1'b1});
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] code_of(input int c);
    case (c)
      0:       return shadow_cfg.code_set;
      1:       return shadow_cfg.code_put;
      2:       return shadow_cfg.code_get;
      3:       return shadow_cfg.code_fpt;
      default: return shadow_cfg.code_fgt;
    endcase
  endfunction

  function automatic logic [7:0] unknown_code();
    logic [7:0] op;
    do op = 8'($urandom); while (classify(op) != K_NONE);
    return op;
  endfunction

  // one rx beat; valid stays high into the next call when no gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_reply(b);
    bytes_sent++;
  endtask

  task automatic send_request(input bytes_t body, input bit bad_sum);
    logic [7:0] sum;
    sum = 8'd0;
    send_byte(shadow_cfg.sync);
    foreach (body[i]) begin
      send_byte(body[i]);
      sum = sum + body[i];
    end
    send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic send_block_write(input logic [7:0] op, input logic [7:0] addr,
                                  input logic [7:0] len, input bit bad_sum);
    bytes_t body;
    body = '{op, addr, len};
    repeat (len) body.push_back(8'($urandom));
    send_request(body, bad_sum);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reply_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC:       shadow_cfg.sync       = val;
      REG_REPLY_SYNC: shadow_cfg.reply_sync = val;
      REG_CODE_SET:   shadow_cfg.code_set   = val;
      REG_CODE_PUT:   shadow_cfg.code_put   = val;
      REG_CODE_GET:   shadow_cfg.code_get   = val;
      REG_CODE_FPT:   shadow_cfg.code_fpt   = val;
      REG_CODE_FGT:   shadow_cfg.code_fgt   = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic reset_shadow();
    shadow_cfg = '{sync: 8'd170, reply_sync: 8'd85, code_set: 8'd1, code_put: 8'd2,
                   code_get: 8'd3, code_fpt: 8'd4, code_fgt: 8'd5};
    eng_phase  = PH_HUNT;
    eng_opcode = 8'd0;
    eng_addr   = 8'd0;
    eng_len    = 8'd0;
    eng_mask   = 8'd0;
    eng_shift  = 8'd0;
    eng_index  = 8'd0;
    eng_sum    = 8'd0;
    foreach (eng_payload[i]) eng_payload[i] = 8'd0;
    foreach (eng_store[i]) eng_store[i] = 8'd0;
  endtask

  task automatic test_reset_contents();
    send_request('{code_of(2), GET_BASE, 8'(STORE_BYTES)}, 1'b0);
    send_request('{code_of(4), GET_BASE + 8'd1, 8'hFF, 8'd0}, 1'b0);
  endtask

  task automatic test_operations();
    send_request('{code_of(0), SET_BASE, 8'hFF, 8'd0, 8'hFF}, 1'b0);
    send_request('{code_of(3), SET_BASE + 8'd1, 8'hF0, 8'd4, 8'h0F}, 1'b0);
    send_request('{code_of(2), GET_BASE, 8'd2}, 1'b0);
    send_request('{code_of(1), 8'd0, 8'd2, 8'h00, 8'hFF}, 1'b0);
    send_request('{code_of(4), GET_BASE + 8'd1, 8'h3C, 8'd2}, 1'b0);
    // write and read running past the end of the store
    send_request('{code_of(1), 8'(STORE_BYTES - 1), 8'd2, 8'h5A, 8'hA5}, 1'b0);
    send_request('{code_of(2), GET_BASE + 8'(STORE_BYTES - 1), 8'd2}, 1'b0);
    send_request('{code_of(4), GET_BASE, 8'hFF, 8'd8}, 1'b0);
    send_request('{code_of(0), SET_BASE, 8'hFF, 8'd255, 8'h77}, 1'b0);
    send_request('{code_of(4), GET_BASE, 8'hFF, 8'd255}, 1'b0);
  endtask

  task automatic test_error_status();
    send_request('{code_of(0), SET_BASE, 8'hFF, 8'd0, 8'h12}, 1'b1);
    send_request('{code_of(0), SET_BASE - 8'd1, 8'hFF, 8'd0, 8'h12}, 1'b0);
    send_request('{code_of(3), SET_BASE + 8'(STORE_BYTES), 8'hFF, 8'd0, 8'h12}, 1'b0);
    send_request('{code_of(1), 8'd0, 8'd0}, 1'b0);
    send_block_write(code_of(1), 8'd0, 8'(STORE_BYTES + 1), 1'b0);
    send_block_write(code_of(1), 8'(STORE_BYTES), 8'd5, 1'b0);
    send_block_write(code_of(1), 8'd0, 8'd24, 1'b0);
    send_request('{code_of(2), GET_BASE, 8'd0}, 1'b0);
    send_request('{code_of(2), GET_BASE, 8'd255}, 1'b0);
    send_request('{code_of(2), GET_BASE - 8'd1, 8'd1}, 1'b0);
    send_request('{code_of(4), GET_BASE + 8'(STORE_BYTES), 8'hFF, 8'd0}, 1'b0);
    send_request('{code_of(4), 8'd255, 8'hFF, 8'd0}, 1'b1);
    // noise then an unknown opcode, which drops back to hunting
    send_byte(shadow_cfg.sync + 8'd1);
    send_byte(shadow_cfg.sync);
    send_byte(unknown_code());
    send_byte(8'd0);
    send_request('{code_of(2), GET_BASE, 8'd1}, 1'b0);
  endtask

  task automatic test_code_settings();
    settle();
    write_cfg(REG_SYNC, 8'h00);
    write_cfg(REG_REPLY_SYNC, 8'hFF);
    write_cfg(REG_CODE_SET, 8'hFF);
    write_cfg(REG_CODE_PUT, 8'h00);
    write_cfg(REG_CODE_GET, 8'h80);
    write_cfg(REG_CODE_FPT, 8'hFE);
    write_cfg(REG_CODE_FGT, 8'h7F);
    send_request('{8'hFF, SET_BASE + 8'd1, 8'hFF, 8'd1, 8'h81}, 1'b0);
    send_request('{8'h00, 8'd0, 8'd1, 8'hFF}, 1'b0);
    send_request('{8'hFE, SET_BASE, 8'h0F, 8'd3, 8'hFF}, 1'b0);
    send_request('{8'h80, GET_BASE, 8'd2}, 1'b0);
    send_request('{8'h7F, GET_BASE + 8'd1, 8'hFF, 8'd1}, 1'b0);
    settle();
    write_cfg(REG_SYNC, 8'hFF);
    write_cfg(REG_REPLY_SYNC, 8'h00);
    send_byte(8'h00);
    send_request('{8'h80, GET_BASE, 8'd2}, 1'b0);
    // colliding codes: set beats put, get beats field get
    settle();
    write_cfg(REG_CODE_PUT, 8'hFF);
    write_cfg(REG_CODE_FGT, 8'h80);
    send_request('{8'hFF, SET_BASE, 8'hFF, 8'd0, 8'h3C}, 1'b0);
    send_request('{8'h80, GET_BASE, 8'd2}, 1'b0);
    settle();
    write_cfg(REG_SYNC, 8'd170);
    write_cfg(REG_REPLY_SYNC, 8'd85);
    write_cfg(REG_CODE_SET, 8'd1);
    write_cfg(REG_CODE_PUT, 8'd2);
    write_cfg(REG_CODE_GET, 8'd3);
    write_cfg(REG_CODE_FPT, 8'd4);
    write_cfg(REG_CODE_FGT, 8'd5);
  endtask

  task automatic test_codes_renamed_mid_packet();
    logic [7:0] old_code, old_fgt;
    // block read whose opcode becomes unknown before the checksum
    old_code = shadow_cfg.code_get;
    send_byte(shadow_cfg.sync);
    send_byte(old_code);
    send_byte(GET_BASE);
    send_byte(8'd2);
    settle();
    write_cfg(REG_CODE_GET, unknown_code());
    send_byte(old_code + GET_BASE + 8'd2);
    settle();
    write_cfg(REG_CODE_GET, old_code);
    // single write turned into a field read before its shift byte
    old_code = shadow_cfg.code_set;
    old_fgt  = shadow_cfg.code_fgt;
    send_byte(shadow_cfg.sync);
    send_byte(old_code);
    send_byte(GET_BASE + 8'd1);
    send_byte(8'hFF);
    settle();
    write_cfg(REG_CODE_FGT, old_code);
    write_cfg(REG_CODE_SET, unknown_code());
    send_byte(8'd2);
    send_byte(old_code + GET_BASE + 8'd1 + 8'hFF + 8'd2);
    settle();
    write_cfg(REG_CODE_SET, old_code);
    write_cfg(REG_CODE_FGT, old_fgt);
  endtask

  task automatic random_config();
    logic [7:0] codes[5];
    while (eng_phase != PH_HUNT) send_byte(8'($urandom));
    settle();
    foreach (codes[i]) codes[i] = 8'($urandom);
    if ($urandom_range(0, 3) == 0) codes[$urandom_range(1, 4)] = codes[$urandom_range(0, 4)];
    write_cfg(REG_SYNC, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
    write_cfg(REG_REPLY_SYNC, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    write_cfg(REG_CODE_SET, codes[0]);
    write_cfg(REG_CODE_PUT, codes[1]);
    write_cfg(REG_CODE_GET, codes[2]);
    write_cfg(REG_CODE_FPT, codes[3]);
    write_cfg(REG_CODE_FGT, codes[4]);
  endtask

  task automatic random_request();
    bytes_t     body;
    int         pick, c;
    logic [7:0] op, addr, len;
    bit         bad_sum;
    pick    = $urandom_range(0, 99);
    c       = $urandom_range(0, 4);
    op      = (pick < 10) ? unknown_code() : code_of(c);
    bad_sum = ($urandom_range(0, 9) == 0);
    if (pick < 5) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (c == 1) begin
      addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, STORE_BYTES));
      len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 24)) :
                                           8'($urandom_range(0, STORE_BYTES + 1));
      send_block_write(op, addr, len, bad_sum);
    end else begin
      if (c == 0 || c == 3)
        addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                             SET_BASE + 8'($urandom_range(0, STORE_BYTES));
      else
        addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                             GET_BASE + 8'($urandom_range(0, STORE_BYTES));
      if (c == 2) begin
        len  = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                                             8'($urandom_range(0, STORE_BYTES + 1));
        body = '{op, addr, len};
      end else begin
        body = '{op, addr, 8'($urandom),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8))};
        if (c != 4) body.push_back(8'($urandom));
      end
      // occasionally cut the packet short; the next sync lands inside it
      if (pick >= 95) body = body[0:$urandom_range(0, body.size() - 1)];
      if (pick >= 95) begin
        send_byte(shadow_cfg.sync);
        foreach (body[i]) send_byte(body[i]);
      end else begin
        send_request(body, bad_sum);
      end
    end
  endtask

  task automatic test_random_traffic();
    int start, next_cfg;
    start    = bytes_sent;
    next_cfg = start;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent >= next_cfg) begin
        random_config();
        next_cfg = bytes_sent + 90;
      end
      if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
      random_request();
    end
    burst_mode = 1'b0;
  endtask

  // reply side back-pressure
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    reply_beat_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      reply_beats_seen++;
      if (reply_end === 1'b1) replies_seen++;
      if (pending_reply_bytes.size() == 0) begin
        $display("%0t unexpected reply beat: tx_byte %02h reply_end %b",
                 $time, tx_byte, reply_end);
        errors++;
      end else begin
        want = pending_reply_bytes.pop_front();
        if (tx_byte !== want.data) begin
          $display("%0t tx_byte mismatch: expected %02h actual %02h",
                   $time, want.data, tx_byte);
          errors++;
        end
        if (reply_end !== want.last) begin
          $display("%0t reply_end mismatch: expected %b actual %b",
                   $time, want.last, reply_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d reply beats outstanding",
               $time, cycle_count, pending_reply_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_contents();
    test_operations();
    test_error_status();
    test_code_settings();
    test_codes_renamed_mid_packet();
    test_random_traffic();
    settle();
    $display("covered: %0d rx bytes, %0d replies in %0d beats, %0d config writes",
             bytes_sent, replies_seen, reply_beats_seen, cfg_writes);
    $display("all opcodes, error statuses and code settings, with random stalls");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
